// ===== src/dbpp_pkg.sv =====
// Shared types and constants for the depth-buffered point plotter.
// No dependencies; imported by dbpp_front, dbpp_back and the top level.
package dbpp_pkg;

  localparam int DEPTH_W  = 24;
  localparam int SHADE_W  = 2;
  localparam int KIND_W   = 2;
  localparam int IDX_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int OP_W     = 3;

  // input kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PLOT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR = 2'd2;

  // shade codes
  localparam logic [SHADE_W-1:0] SHADE_BLANK  = 2'd0;
  localparam logic [SHADE_W-1:0] SHADE_FAR    = 2'd1;
  localparam logic [SHADE_W-1:0] SHADE_MIDDLE = 2'd2;
  localparam logic [SHADE_W-1:0] SHADE_NEAR   = 2'd3;

  // classified operations handed from front to back
  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 3'd1;
  localparam logic [OP_W-1:0] OP_PLOT  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ  = 3'd3;
  localparam logic [OP_W-1:0] OP_OFF   = 3'd4;

  // register reset values, Q15.8
  localparam logic signed [DEPTH_W-1:0] RESET_NEAR  = 24'sd15360;
  localparam logic signed [DEPTH_W-1:0] RESET_FAR   = 24'sd10240;
  localparam logic signed [DEPTH_W-1:0] RESET_CLEAR = -24'sd256000;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [DEPTH_W-1:0] depth;
  } cmd_t;

  typedef struct packed {
    logic signed [DEPTH_W-1:0] near_thr;
    logic signed [DEPTH_W-1:0] far_thr;
    logic signed [DEPTH_W-1:0] clear_depth;
  } cfg_t;

endpackage

// ===== src/dbpp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dbpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/dbpp_front.sv =====
// Front end: takes input transactions, classifies them and computes the
// pixel address, then holds them in a two-entry queue. Uses dbpp_pkg.
module dbpp_front #(
  parameter int SCREEN_SIDE = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [dbpp_pkg::KIND_W-1:0]           kind,
  input  logic signed [dbpp_pkg::IDX_W-1:0]     row_index,
  input  logic signed [dbpp_pkg::IDX_W-1:0]     col_index,
  input  logic signed [dbpp_pkg::DEPTH_W-1:0]   depth_value,
  input  logic                                  hold,
  output logic                                  head_valid,
  output dbpp_pkg::cmd_t                        head_cmd,
  output logic [$clog2(SCREEN_SIDE*SCREEN_SIDE)-1:0] head_addr,
  input  logic                                  pop
);
  import dbpp_pkg::*;

  localparam int AW = $clog2(SCREEN_SIDE * SCREEN_SIDE);
  localparam int RW = $clog2(SCREEN_SIDE);
  localparam logic [AW-1:0] SIDE_A = AW'(SCREEN_SIDE);

  cmd_t          q_cmd  [2];
  logic [AW-1:0] q_addr [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  cmd_t          new_cmd;
  logic [AW-1:0] new_addr;
  logic          row_ok;
  logic          col_ok;
  logic          push;

  assign row_ok = !row_index[IDX_W-1] &&
                  ({1'b0, row_index} < (IDX_W+1)'(SCREEN_SIDE));
  assign col_ok = !col_index[IDX_W-1] &&
                  ({1'b0, col_index} < (IDX_W+1)'(SCREEN_SIDE));
  assign new_addr = AW'(row_index[RW-1:0]) * SIDE_A + AW'(col_index[RW-1:0]);

  always_comb begin
    new_cmd.depth = depth_value;
    case (kind) inside
      KIND_CLEAR:           new_cmd.op = OP_CLEAR;
      KIND_PLOT, KIND_READ: begin
        if (row_ok && col_ok) begin
          new_cmd.op = (kind == KIND_PLOT) ? OP_PLOT : OP_READ;
        end else begin
          new_cmd.op = OP_OFF;
        end
      end
      default:              new_cmd.op = OP_NOP;
    endcase
  end

  assign in_ready   = (count != 2'd2) && !hold;
  assign push       = in_valid && in_ready;
  assign head_valid = (count != 2'd0);
  assign head_cmd   = q_cmd[rd_ptr];
  assign head_addr  = q_addr[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_cmd[wr_ptr]  <= new_cmd;
      q_addr[wr_ptr] <= new_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== src/dbpp_back.sv =====
// Back end: runs queued commands against the pixel and depth stores
// (two dbpp_ram instances), sweeps the stores on clear and after reset,
// and owns the output register. Uses dbpp_pkg and dbpp_ram.
module dbpp_back #(
  parameter int SCREEN_SIDE = 128
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dbpp_pkg::cfg_t                        cfg,
  input  logic                                  head_valid,
  input  dbpp_pkg::cmd_t                        head_cmd,
  input  logic [$clog2(SCREEN_SIDE*SCREEN_SIDE)-1:0] head_addr,
  output logic                                  pop,
  output logic                                  init_busy,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [dbpp_pkg::SHADE_W-1:0]          shade_code,
  output logic signed [dbpp_pkg::DEPTH_W-1:0]   stored_depth,
  output logic                                  written,
  output logic                                  off_screen
);
  import dbpp_pkg::*;

  localparam int NPIX = SCREEN_SIDE * SCREEN_SIDE;
  localparam int AW   = $clog2(NPIX);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [AW-1:0]             sweep_cnt;
  logic signed [DEPTH_W-1:0] sweep_depth;
  logic [AW-1:0]             cur_addr;
  logic signed [DEPTH_W-1:0] cur_depth;
  logic                      cur_plot;

  logic                      out_free;
  logic                      load;
  logic [SHADE_W-1:0]        res_shade;
  logic signed [DEPTH_W-1:0] res_depth;
  logic                      res_written;
  logic                      res_off;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [SHADE_W-1:0]        ram_wshade;
  logic [DEPTH_W-1:0]        ram_wdepth;
  logic [AW-1:0]             ram_raddr;
  logic [SHADE_W-1:0]        rd_shade;
  logic [DEPTH_W-1:0]        rd_depth_raw;
  logic signed [DEPTH_W-1:0] rd_depth;
  logic                      upd;
  logic [SHADE_W-1:0]        new_shade;

  assign out_free = !out_valid || out_ready;
  assign rd_depth = $signed(rd_depth_raw);
  assign upd      = cur_plot && (cur_depth > rd_depth);

  always_comb begin
    if (cur_depth > cfg.near_thr) begin
      new_shade = SHADE_NEAR;
    end else if (cur_depth < cfg.far_thr) begin
      new_shade = SHADE_FAR;
    end else begin
      new_shade = SHADE_MIDDLE;
    end
  end

  // read address is taken from the queue head while idle, then held
  assign ram_raddr = (state == ST_IDLE) ? head_addr : cur_addr;

  dbpp_ram #(.WIDTH(SHADE_W), .DEPTH(NPIX)) u_pixel_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wshade),
    .raddr (ram_raddr),
    .rdata (rd_shade)
  );

  dbpp_ram #(.WIDTH(DEPTH_W), .DEPTH(NPIX)) u_depth_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdepth),
    .raddr (ram_raddr),
    .rdata (rd_depth_raw)
  );

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load        = 1'b0;
    res_shade   = SHADE_BLANK;
    res_depth   = '0;
    res_written = 1'b0;
    res_off     = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = cur_addr;
    ram_wshade  = new_shade;
    ram_wdepth  = cur_depth;
    case (state)
      ST_IDLE: begin
        if (head_valid) begin
          case (head_cmd.op)
            OP_PLOT, OP_READ: begin
              pop        = 1'b1;
              state_next = ST_EXEC;
            end
            OP_CLEAR: begin
              if (out_free) begin
                pop        = 1'b1;
                load       = 1'b1;
                res_depth  = cfg.clear_depth;
                state_next = ST_SWEEP;
              end
            end
            OP_OFF: begin
              if (out_free) begin
                pop     = 1'b1;
                load    = 1'b1;
                res_off = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                pop  = 1'b1;
                load = 1'b1;
              end
            end
          endcase
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          load        = 1'b1;
          res_written = upd;
          res_shade   = upd ? new_shade : rd_shade;
          res_depth   = upd ? cur_depth : rd_depth;
          ram_we      = upd;
          state_next  = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        ram_we     = 1'b1;
        ram_waddr  = sweep_cnt;
        ram_wshade = SHADE_BLANK;
        ram_wdepth = sweep_depth;
        if (sweep_cnt == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_cnt   <= '0;
      sweep_depth <= RESET_CLEAR;
      init_busy   <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SWEEP) begin
        sweep_cnt <= sweep_cnt + AW'(1);
        if (sweep_cnt == LAST_ADDR) begin
          init_busy <= 1'b0;
        end
      end
      if (state == ST_IDLE && pop && head_cmd.op == OP_CLEAR) begin
        sweep_cnt   <= '0;
        sweep_depth <= cfg.clear_depth;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop) begin
      cur_addr  <= head_addr;
      cur_depth <= head_cmd.depth;
      cur_plot  <= (head_cmd.op == OP_PLOT);
    end
    if (load) begin
      shade_code   <= res_shade;
      stored_depth <= res_depth;
      written      <= res_written;
      off_screen   <= res_off;
    end
  end

  // nothing leaves the queue while the stores are being swept
  assert property (@(posedge clk) disable iff (rst) state == ST_SWEEP |-> !pop)
    else $error("queue popped during store sweep");

  // an executing lookup finishes as soon as the output register is free
  assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && out_free |=> state == ST_IDLE && out_valid)
    else $error("lookup did not complete");

  // an update always leaves a real shade and never comes from an off-screen point
  assert property (@(posedge clk) disable iff (rst)
    out_valid && written |-> !off_screen && shade_code != SHADE_BLANK)
    else $error("bad update result");

  // dropped points report an empty pixel
  assert property (@(posedge clk) disable iff (rst)
    out_valid && off_screen |-> stored_depth == 0 && shade_code == SHADE_BLANK)
    else $error("off-screen result not empty");

  // the store write port is used only by a sweep or by an update
  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == ST_SWEEP || (state == ST_EXEC && upd))
    else $error("unexpected store write");

endmodule

// ===== src/depth_buffered_point_plotter_core.sv =====
// Top level of the depth-buffered point plotter: configuration registers,
// front end (dbpp_front) and back end (dbpp_back). Uses dbpp_pkg.
//
// Usage:
//  - Input channel (in_valid/in_ready): kind, row_index, col_index,
//    depth_value. Kind clear resets both stores, plot does a depth test and
//    conditional update, read reports one pixel. Exactly one result
//    transaction comes out per input transaction, in order.
//  - Output channel (out_valid/out_ready): shade_code, stored_depth,
//    written, off_screen, held in an output register.
//  - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//    writes near threshold, far threshold or clear depth; other indexes
//    are ignored. Write only while the block is idle.
//  - Processing: plot and read go through a registered store read, then
//    compare and write back; off-screen, unused and the clear result
//    load the output register directly. A clear then sweeps all
//    SCREEN_SIDE*SCREEN_SIDE store entries, one a cycle, before the next
//    command runs.
//  - Reset: stores are swept the same way (SCREEN_SIDE*SCREEN_SIDE entries,
//    16384 by default) with in_ready low. A stalled receiver holds the
//    output register; the two-entry queue keeps accepting until full.
module depth_buffered_point_plotter_core #(
  parameter int SCREEN_SIDE = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dbpp_pkg::KIND_W-1:0]         kind,
  input  logic signed [dbpp_pkg::IDX_W-1:0]   row_index,
  input  logic signed [dbpp_pkg::IDX_W-1:0]   col_index,
  input  logic signed [dbpp_pkg::DEPTH_W-1:0] depth_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dbpp_pkg::SHADE_W-1:0]        shade_code,
  output logic signed [dbpp_pkg::DEPTH_W-1:0] stored_depth,
  output logic                                written,
  output logic                                off_screen,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dbpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbpp_pkg::DEPTH_W-1:0]        cfg_data
);
  import dbpp_pkg::*;

  localparam int AW = $clog2(SCREEN_SIDE * SCREEN_SIDE);

  cfg_t          cfg;
  logic          head_valid;
  cmd_t          head_cmd;
  logic [AW-1:0] head_addr;
  logic          pop;
  logic          init_busy;

  assign cfg_ready = 1'b1;

  // configuration registers, 24-bit two's complement
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.near_thr    <= RESET_NEAR;
      cfg.far_thr     <= RESET_FAR;
      cfg.clear_depth <= RESET_CLEAR;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NEAR:  cfg.near_thr    <= $signed(cfg_data);
        CFG_FAR:   cfg.far_thr     <= $signed(cfg_data);
        CFG_CLEAR: cfg.clear_depth <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // front: classify and queue
  dbpp_front #(.SCREEN_SIDE(SCREEN_SIDE)) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .row_index   (row_index),
    .col_index   (col_index),
    .depth_value (depth_value),
    .hold        (init_busy),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .head_addr   (head_addr),
    .pop         (pop)
  );

  // back: store access, sweeps, output register
  dbpp_back #(.SCREEN_SIDE(SCREEN_SIDE)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head_valid   (head_valid),
    .head_cmd     (head_cmd),
    .head_addr    (head_addr),
    .pop          (pop),
    .init_busy    (init_busy),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .shade_code   (shade_code),
    .stored_depth (stored_depth),
    .written      (written),
    .off_screen   (off_screen)
  );

endmodule
